### hdl/vir_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// Video interface register package
// Register numbers, operation codes, reset values, write masks and the
// request and result types shared by the register block.
// ============================================================================
package vir_pkg;

    localparam int NumRegs   = 16;
    localparam int RegWidth  = 32;
    localparam int LineWidth = 10;

    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    localparam logic [3:0] REG_CTRL     = 4'd0;
    localparam logic [3:0] REG_ORIGIN   = 4'd1;
    localparam logic [3:0] REG_WIDTH    = 4'd2;
    localparam logic [3:0] REG_VINTR    = 4'd3;
    localparam logic [3:0] REG_VCURRENT = 4'd4;
    localparam logic [3:0] REG_BURST    = 4'd5;
    localparam logic [3:0] REG_VSYNC    = 4'd6;
    localparam logic [3:0] REG_HSYNC    = 4'd7;
    localparam logic [3:0] REG_HLEAP    = 4'd8;
    localparam logic [3:0] REG_HVIDEO   = 4'd9;
    localparam logic [3:0] REG_VVIDEO   = 4'd10;
    localparam logic [3:0] REG_VBURST   = 4'd11;
    localparam logic [3:0] REG_XSCALE   = 4'd12;
    localparam logic [3:0] REG_YSCALE   = 4'd13;
    localparam logic [3:0] REG_TESTADDR = 4'd14;
    localparam logic [3:0] REG_STAGED   = 4'd15;

    localparam logic [9:0]  VSYNC_DEFAULT  = 10'h20D;
    localparam logic [9:0]  LINE_CMP_MASK  = 10'h3FE;
    localparam int          CtrlInterlace  = 6;

    typedef struct packed {
        logic [1:0]  mode;
        logic [3:0]  reg_index;
        logic [31:0] write_data;
    } req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        intr_raise;
        logic        intr_clear;
        logic        frame_end;
    } rsp_t;

    function automatic logic [31:0] write_mask(input logic [3:0] idx);
        logic [31:0] m;
        case (idx)
            REG_CTRL:     m = 32'hFFFF_FFFF;
            REG_ORIGIN:   m = 32'h00FF_FFFF;
            REG_WIDTH:    m = 32'h0000_0FFF;
            REG_VINTR:    m = 32'h0000_03FF;
            REG_VCURRENT: m = 32'h0000_0000;
            REG_BURST:    m = 32'h3FFF_FFFF;
            REG_VSYNC:    m = 32'h0000_03FF;
            REG_HSYNC:    m = 32'h001F_0FFF;
            REG_HLEAP:    m = 32'h0FFF_0FFF;
            REG_HVIDEO:   m = 32'h03FF_03FF;
            REG_VVIDEO:   m = 32'h03FF_03FF;
            REG_VBURST:   m = 32'h03FF_03FF;
            REG_XSCALE:   m = 32'h0FFF_0FFF;
            REG_YSCALE:   m = 32'h0FFF_0FFF;
            REG_TESTADDR: m = 32'h0000_007F;
            default:      m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic logic [31:0] reset_value(input logic [3:0] idx);
        logic [31:0] v;
        case (idx)
            REG_CTRL:  v = 32'h0000_0003;
            REG_WIDTH: v = 32'd320;
            REG_VINTR: v = 32'h0000_03FF;
            REG_BURST: v = 32'h0000_0001;
            REG_VSYNC: v = {22'd0, VSYNC_DEFAULT};
            REG_HSYNC: v = 32'h0015_07FF;
            default:   v = 32'h0000_0000;
        endcase
        return v;
    endfunction

endpackage

### hdl/vir_if.sv
`timescale 1ns / 1ps
// ============================================================================
// Video interface register channels
// Request channel (bus access or half-line tick) and result channel, each
// with a valid/ready handshake.
// ============================================================================
interface vir_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [3:0]  reg_index;
    logic [31:0] write_data;

    modport source (output valid, output mode, output reg_index, output write_data,
                    input ready);
    modport sink (input valid, input mode, input reg_index, input write_data,
                  output ready);
endinterface

interface vir_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic        intr_raise;
    logic        intr_clear;
    logic        frame_end;

    modport source (output valid, output read_data, output intr_raise,
                    output intr_clear, output frame_end, input ready);
    modport sink (input valid, input read_data, input intr_raise,
                  input intr_clear, input frame_end, output ready);
endinterface

### hdl/vir_in_stage.sv
`timescale 1ns / 1ps
// ============================================================================
// Video interface register input stage
// Holds one accepted request until the core commits it.
// ============================================================================
module vir_in_stage
(
    input  logic          clk,
    input  logic          rst_n,
    vir_req_if.sink       req,
    input  logic          advance,
    output logic          hold_valid,
    output vir_pkg::req_t hold_req
);

    logic          hold_valid_reg;
    logic          hold_valid_next;
    vir_pkg::req_t hold_reg;
    logic          take;

    assign req.ready = !hold_valid_reg || advance;
    assign take      = req.valid && req.ready;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (take)
        begin
            hold_valid_next = 1'b1;
        end
        else if (advance)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hold_reg.mode       <= req.mode;
            hold_reg.reg_index  <= req.reg_index;
            hold_reg.write_data <= req.write_data;
        end
    end

    assign hold_valid = hold_valid_reg;
    assign hold_req   = hold_reg;

endmodule

### hdl/vir_core.sv
`timescale 1ns / 1ps
// ============================================================================
// Video interface register core
// Register file, line counter and the per-request update and result logic.
// ============================================================================
module vir_core
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          commit,
    input  vir_pkg::req_t hold_req,
    output vir_pkg::rsp_t result
);

    logic [31:0] regs_reg [vir_pkg::NumRegs];
    logic [vir_pkg::LineWidth-1:0] vcur_reg;
    logic [vir_pkg::LineWidth-1:0] vcur_next;

    logic [vir_pkg::LineWidth:0]   vcur_sum;
    logic [vir_pkg::LineWidth-1:0] vsync;
    logic [vir_pkg::LineWidth-1:0] vintr;
    logic [vir_pkg::LineWidth-1:0] cmp_mask;
    logic [31:0] ctrl;
    logic        is_read;
    logic        is_write;
    logic        is_tick;
    logic        wrap;
    logic [31:0] wr_value;

    assign ctrl     = regs_reg[vir_pkg::REG_CTRL];
    assign vsync    = regs_reg[vir_pkg::REG_VSYNC][vir_pkg::LineWidth-1:0];
    assign vintr    = regs_reg[vir_pkg::REG_VINTR][vir_pkg::LineWidth-1:0];
    assign is_read  = hold_req.mode == vir_pkg::MODE_READ;
    assign is_write = hold_req.mode == vir_pkg::MODE_WRITE;
    assign is_tick  = hold_req.mode == vir_pkg::MODE_TICK;

    // A tick without a wrap leaves the counter below a ten-bit sync limit and a
    // wrap leaves it at zero or one, so ten bits hold the counter.
    assign vcur_sum = {1'b0, vcur_reg} + 11'd2;
    assign wrap     = vcur_sum >= {1'b0, vsync};
    assign cmp_mask = vir_pkg::LINE_CMP_MASK | {9'd0, ~vsync[0]};

    always_comb
    begin
        if (wrap)
        begin
            vcur_next = {9'd0, ~vcur_sum[0] & ctrl[vir_pkg::CtrlInterlace]};
        end
        else
        begin
            vcur_next = vcur_sum[vir_pkg::LineWidth-1:0];
        end
    end

    always_comb
    begin
        if (hold_req.reg_index == vir_pkg::REG_VSYNC)
        begin
            if (hold_req.write_data[9:0] != 10'd0)
            begin
                wr_value = {22'd0, hold_req.write_data[9:0]};
            end
            else
            begin
                wr_value = {22'd0, vir_pkg::VSYNC_DEFAULT};
            end
        end
        else
        begin
            wr_value = hold_req.write_data & vir_pkg::write_mask(hold_req.reg_index);
        end
    end

    always_comb
    begin
        result = '0;
        if (is_read)
        begin
            if (hold_req.reg_index == vir_pkg::REG_VCURRENT)
            begin
                result.read_data = {22'd0, vcur_reg};
            end
            else
            begin
                result.read_data = regs_reg[hold_req.reg_index];
            end
        end
        if (is_write && hold_req.reg_index == vir_pkg::REG_VCURRENT)
        begin
            result.intr_clear = 1'b1;
        end
        if (is_tick)
        begin
            result.frame_end  = wrap;
            result.intr_raise = (ctrl[1:0] != 2'd0)
                                && ((vcur_next & cmp_mask) == (vintr & cmp_mask));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < vir_pkg::NumRegs; i++)
            begin
                regs_reg[i] <= vir_pkg::reset_value(4'(i));
            end
            vcur_reg <= '0;
        end
        else if (commit)
        begin
            if (is_write && hold_req.reg_index != vir_pkg::REG_VCURRENT)
            begin
                regs_reg[hold_req.reg_index] <= wr_value;
            end
            if (is_tick)
            begin
                vcur_reg <= vcur_next;
            end
        end
    end

    a_wrap_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        commit && result.frame_end |=> vcur_reg <= 10'd1)
        else $error("Line counter did not restart after a wrap.");

    a_vsync_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> regs_reg[vir_pkg::REG_VSYNC] != 32'd0
                   && regs_reg[vir_pkg::REG_VSYNC][31:10] == 22'd0)
        else $error("Vertical sync limit is zero or out of range.");

    a_counter_held: assert property (@(posedge clk) disable iff (!rst_n)
        commit && !is_tick |=> $stable(vcur_reg))
        else $error("Line counter changed on a bus access.");

    a_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
        commit && is_tick && !wrap |=> vcur_reg < vsync)
        else $error("Line counter passed the sync limit without a wrap.");

endmodule

### hdl/vir_out_stage.sv
`timescale 1ns / 1ps
// ============================================================================
// Video interface register output stage
// Result register that drives the result channel.
// ============================================================================
module vir_out_stage
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  vir_pkg::rsp_t result,
    output logic          can_load,
    vir_rsp_if.source     rsp
);

    logic          out_valid_reg;
    logic          out_valid_next;
    vir_pkg::rsp_t out_reg;

    assign can_load = !out_valid_reg || rsp.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= result;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_data  = out_reg.read_data;
    assign rsp.intr_raise = out_reg.intr_raise;
    assign rsp.intr_clear = out_reg.intr_clear;
    assign rsp.frame_end  = out_reg.frame_end;

endmodule

### hdl/video_interface_registers.sv
`timescale 1ns / 1ps
// ============================================================================
// Video interface registers
// Sixteen timing registers with bus read and write and a half-line tick.
// ============================================================================
// Each request is a register read, a masked register write or a half-line
// tick, and each produces exactly one result. The block takes one request
// per cycle while the result channel does not stall it; a request passes
// through the input register and then the result register, and the
// line counter update, masked write and interrupt compare all finish in the
// single logic step between them. Backpressure on the result channel stalls
// the input only once both registers are full.
module video_interface_registers
(
    input  logic      clk,
    input  logic      rst_n,
    vir_req_if.sink   req,
    vir_rsp_if.source rsp
);

    logic          hold_valid;
    vir_pkg::req_t hold_req;
    vir_pkg::rsp_t result;
    logic          can_load;
    logic          advance;

    assign advance = hold_valid && can_load;

    vir_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .advance    (advance),
        .hold_valid (hold_valid),
        .hold_req   (hold_req)
    );

    vir_core u_core
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .commit   (advance),
        .hold_req (hold_req),
        .result   (result)
    );

    vir_out_stage u_out_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .result   (result),
        .can_load (can_load),
        .rsp      (rsp)
    );

endmodule
